### sv/vector_two_source_alu_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the vector two-source ALU
// Property forms used by the top-level ALU module to check its own logic.
// ---------------------------------------------------------------------------
`ifndef VECTOR_TWO_SOURCE_ALU_ASSERT_SVH
`define VECTOR_TWO_SOURCE_ALU_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VTSA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vector_two_source_alu: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define VTSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vector_two_source_alu: next-cycle check failed");

`endif

### sv/vtsa_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector two-source ALU package
// Operation codes, widths and pipeline control types shared by the ALU files.
// ---------------------------------------------------------------------------
package vtsa_pkg;

    localparam int ReqTypeW = 5;
    localparam int DataW    = 64;
    localparam int HalfW    = 32;
    localparam int Mul24W   = 24;
    localparam int Mul24OpW = Mul24W + 1;
    localparam int Mul24PW  = 2 * Mul24OpW;
    localparam int Sh32W    = 5;
    localparam int Sh64W    = 6;

    typedef enum logic [ReqTypeW-1:0] {
        OP_ADD32     = 5'd0,
        OP_SUB32     = 5'd1,
        OP_SUBREV32  = 5'd2,
        OP_MUL_I24   = 5'd3,
        OP_MUL_U24   = 5'd4,
        OP_MULHI_I24 = 5'd5,
        OP_MULHI_U24 = 5'd6,
        OP_MIN_I32   = 5'd7,
        OP_MAX_I32   = 5'd8,
        OP_MIN_U32   = 5'd9,
        OP_MAX_U32   = 5'd10,
        OP_AND32     = 5'd11,
        OP_OR32      = 5'd12,
        OP_XOR32     = 5'd13,
        OP_XNOR32    = 5'd14,
        OP_LSHLREV32 = 5'd15,
        OP_LSHRREV32 = 5'd16,
        OP_ASHRREV32 = 5'd17,
        OP_ADD64     = 5'd18,
        OP_SUB64     = 5'd19,
        OP_MUL64     = 5'd20,
        OP_LSHLREV64 = 5'd21
    } t_op;

    typedef struct packed {
        logic en1;
        logic en2;
    } t_stage_ctl;

endpackage

### sv/vtsa_int_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector two-source ALU integer unit
// Adds, subtracts, compares, logic and shifts, with a registered result.
// ---------------------------------------------------------------------------
module vtsa_int_unit
    import vtsa_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  t_op              i_op,
    input  logic [DataW-1:0] i_src_a,
    input  logic [DataW-1:0] i_src_b,
    output logic [DataW-1:0] o_result
);

    logic [DataW-1:0] r_result;
    logic [DataW-1:0] n_result;
    logic [HalfW-1:0] a32;
    logic [HalfW-1:0] b32;

    assign a32 = i_src_a[HalfW-1:0];
    assign b32 = i_src_b[HalfW-1:0];

    always_comb begin
        n_result = '0;
        case (i_op)
            OP_ADD32:     n_result = {{(DataW-HalfW){1'b0}}, a32 + b32};
            OP_SUB32:     n_result = {{(DataW-HalfW){1'b0}}, a32 - b32};
            OP_SUBREV32:  n_result = {{(DataW-HalfW){1'b0}}, b32 - a32};
            OP_MIN_I32:   n_result = {{(DataW-HalfW){1'b0}},
                                      ($signed(a32) < $signed(b32)) ? a32 : b32};
            OP_MAX_I32:   n_result = {{(DataW-HalfW){1'b0}},
                                      ($signed(a32) > $signed(b32)) ? a32 : b32};
            OP_MIN_U32:   n_result = {{(DataW-HalfW){1'b0}}, (a32 < b32) ? a32 : b32};
            OP_MAX_U32:   n_result = {{(DataW-HalfW){1'b0}}, (a32 > b32) ? a32 : b32};
            OP_AND32:     n_result = {{(DataW-HalfW){1'b0}}, a32 & b32};
            OP_OR32:      n_result = {{(DataW-HalfW){1'b0}}, a32 | b32};
            OP_XOR32:     n_result = {{(DataW-HalfW){1'b0}}, a32 ^ b32};
            OP_XNOR32:    n_result = {{(DataW-HalfW){1'b0}}, ~(a32 ^ b32)};
            OP_LSHLREV32: n_result = {{(DataW-HalfW){1'b0}}, b32 << a32[Sh32W-1:0]};
            OP_LSHRREV32: n_result = {{(DataW-HalfW){1'b0}}, b32 >> a32[Sh32W-1:0]};
            OP_ASHRREV32: n_result = {{(DataW-HalfW){1'b0}},
                                      $unsigned($signed(b32) >>> a32[Sh32W-1:0])};
            OP_ADD64:     n_result = i_src_a + i_src_b;
            OP_SUB64:     n_result = i_src_a - i_src_b;
            OP_LSHLREV64: n_result = i_src_b << i_src_a[Sh64W-1:0];
            default:      n_result = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

endmodule

### sv/vtsa_mul_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector two-source ALU multiplier
// Two-stage multiplier: registered partial products and 24-bit product, then the 64-bit sum.
// ---------------------------------------------------------------------------
module vtsa_mul_unit
    import vtsa_pkg::*;
(
    input  logic             i_clk,
    input  t_stage_ctl       i_ctl,
    input  t_op              i_op,
    input  logic [DataW-1:0] i_src_a,
    input  logic [DataW-1:0] i_src_b,
    output logic [DataW-1:0] o_mul64,
    output logic [DataW-1:0] o_mul24
);

    logic                       is_signed;
    logic signed [Mul24OpW-1:0] m24_a;
    logic signed [Mul24OpW-1:0] m24_b;

    logic [DataW-1:0]           n_p_ll;
    logic [HalfW-1:0]           n_p_lh;
    logic [HalfW-1:0]           n_p_hl;
    logic signed [Mul24PW-1:0]  n_p24;

    logic [DataW-1:0]           r_p_ll;
    logic [HalfW-1:0]           r_p_lh;
    logic [HalfW-1:0]           r_p_hl;
    logic signed [Mul24PW-1:0]  r_p24;

    logic [DataW-1:0]           n_mul64;
    logic [DataW-1:0]           n_mul24;
    logic [DataW-1:0]           r_mul64;
    logic [DataW-1:0]           r_mul24;

    assign is_signed = (i_op == OP_MUL_I24) || (i_op == OP_MULHI_I24);
    assign m24_a = $signed({is_signed & i_src_a[Mul24W-1], i_src_a[Mul24W-1:0]});
    assign m24_b = $signed({is_signed & i_src_b[Mul24W-1], i_src_b[Mul24W-1:0]});

    assign n_p_ll = {{HalfW{1'b0}}, i_src_a[HalfW-1:0]} *
                    {{HalfW{1'b0}}, i_src_b[HalfW-1:0]};
    assign n_p_lh = i_src_a[HalfW-1:0] * i_src_b[DataW-1:HalfW];
    assign n_p_hl = i_src_a[DataW-1:HalfW] * i_src_b[HalfW-1:0];
    assign n_p24  = {{Mul24OpW{m24_a[Mul24OpW-1]}}, m24_a} *
                    {{Mul24OpW{m24_b[Mul24OpW-1]}}, m24_b};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en1) begin
            r_p_ll <= n_p_ll;
            r_p_lh <= n_p_lh;
            r_p_hl <= n_p_hl;
            r_p24  <= n_p24;
        end
    end

    assign n_mul64 = r_p_ll + {r_p_lh + r_p_hl, {HalfW{1'b0}}};
    assign n_mul24 = {{(DataW-Mul24PW){r_p24[Mul24PW-1]}}, r_p24};

    always_ff @(posedge i_clk) begin
        if (i_ctl.en2) begin
            r_mul64 <= n_mul64;
            r_mul24 <= n_mul24;
        end
    end

    assign o_mul64 = r_mul64;
    assign o_mul24 = r_mul24;

endmodule

### sv/vector_two_source_alu.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector two-source ALU
// Pipelined two-source integer ALU of a vector unit with stream ports.
// ---------------------------------------------------------------------------
// The ALU takes one operation in every cycle while o_s_tready is high and
// returns the results in order; the multiplier registers its partial products
// of the 32-bit halves in the first stage and sums them in the second, with
// the output register as the third stage. Each stage moves on whenever the
// stage after it is empty or moving, so a stall on the output side fills the
// bubbles before input is held off.
module vector_two_source_alu
    import vtsa_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [2*DataW-1:0]  i_s_tdata,  // src_a, src_b
    input  logic [ReqTypeW-1:0] i_s_tuser,  // req_type
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [DataW-1:0]    o_m_tdata,  // result_value
    output logic                o_m_tuser   // result_is_wide
);

    t_stage_ctl       ctl;
    logic             en3;
    logic [DataW-1:0] src_a;
    logic [DataW-1:0] src_b;
    t_op              in_op;

    logic             r_s1_valid;
    t_op              r_s1_op;
    logic [DataW-1:0] s1_int;

    logic             r_s2_valid;
    t_op              r_s2_op;
    logic [DataW-1:0] r_s2_int;
    logic [DataW-1:0] s2_mul64;
    logic [DataW-1:0] s2_mul24;

    logic             r_out_valid;
    logic [DataW-1:0] r_out_data;
    logic             r_out_wide;
    logic [DataW-1:0] n_out_data;
    logic             n_out_wide;

    assign src_a = i_s_tdata[DataW-1:0];
    assign src_b = i_s_tdata[2*DataW-1:DataW];
    assign in_op = t_op'(i_s_tuser);

    assign en3     = !r_out_valid || i_m_tready;
    assign ctl.en2 = !r_s2_valid || en3;
    assign ctl.en1 = !r_s1_valid || ctl.en2;
    assign o_s_tready = ctl.en1;

    vtsa_int_unit u_int (
        .i_clk    (i_clk),
        .i_en     (ctl.en1),
        .i_op     (in_op),
        .i_src_a  (src_a),
        .i_src_b  (src_b),
        .o_result (s1_int)
    );

    vtsa_mul_unit u_mul (
        .i_clk   (i_clk),
        .i_ctl   (ctl),
        .i_op    (in_op),
        .i_src_a (src_a),
        .i_src_b (src_b),
        .o_mul64 (s2_mul64),
        .o_mul24 (s2_mul24)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (ctl.en1) begin
                r_s1_valid <= i_s_tvalid;
            end
            if (ctl.en2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (en3) begin
                r_out_valid <= r_s2_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.en1) begin
            r_s1_op <= in_op;
        end
        if (ctl.en2) begin
            r_s2_op  <= r_s1_op;
            r_s2_int <= s1_int;
        end
        if (en3) begin
            r_out_data <= n_out_data;
            r_out_wide <= n_out_wide;
        end
    end

    always_comb begin
        n_out_wide = 1'b0;
        case (r_s2_op)
            OP_MUL_I24, OP_MUL_U24: begin
                n_out_data = {{(DataW-HalfW){1'b0}}, s2_mul24[HalfW-1:0]};
            end
            OP_MULHI_I24, OP_MULHI_U24: begin
                n_out_data = {{(DataW-HalfW){1'b0}}, s2_mul24[DataW-1:HalfW]};
            end
            OP_MUL64: begin
                n_out_data = s2_mul64;
                n_out_wide = 1'b1;
            end
            OP_ADD64, OP_SUB64, OP_LSHLREV64: begin
                n_out_data = r_s2_int;
                n_out_wide = 1'b1;
            end
            default: begin
                n_out_data = r_s2_int;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_wide;

`include "vector_two_source_alu_assert.svh"

    `VTSA_ASSERT_NEXT(a_s1_held, i_clk, i_rst_n, r_s1_valid && !ctl.en2, r_s1_valid && $stable(r_s1_op))
    `VTSA_ASSERT_NEXT(a_s1_to_s2, i_clk, i_rst_n, r_s1_valid && ctl.en2, r_s2_valid)
    `VTSA_ASSERT_NEXT(a_no_invent, i_clk, i_rst_n, !r_s1_valid && ctl.en2, !r_s2_valid)
    `VTSA_ASSERT_SAME(a_ready_free, i_clk, i_rst_n, !r_s1_valid || !r_s2_valid || !r_out_valid, o_s_tready)

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Vector two-source ALU testbench
// Streams directed and random operations through the ALU under varying
// source gaps and sink back-pressure, and checks every result in order
// against fixed expected values or a local model of the integer operations.
// ---------------------------------------------------------------------------
module tb;
    import vtsa_pkg::*;

    localparam logic [ReqTypeW-1:0] OpUnusedLo = 5'd22;
    localparam logic [ReqTypeW-1:0] OpUnusedHi = 5'd31;
    localparam int DirCount   = 25;
    localparam int PhaseItems = 370;

    typedef struct packed {
        logic [DataW-1:0] value;
        logic             wide;
    } t_alu_word;

    typedef struct packed {
        logic [ReqTypeW-1:0] op;
        logic [DataW-1:0]    a;
        logic [DataW-1:0]    b;
        logic                fixed;
        logic [DataW-1:0]    value;
        logic                wide;
    } t_op_row;

    localparam logic [DataW-1:0] AllOnes = {DataW{1'b1}};

    localparam t_op_row DirRows [DirCount] = '{
        '{OP_ADD32,     AllOnes, 64'hFFFF_FFFF_0000_0001, 1'b1, 64'h0, 1'b0},
        '{OP_SUB32,     64'h0, 64'h1, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_SUBREV32,  64'h1, 64'h0, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_MUL_I24,   64'h0080_0000, 64'hFFFF_0000_0080_0000, 1'b0, 64'h0, 1'b0},
        '{OP_MUL_U24,   AllOnes, AllOnes, 1'b0, 64'h0, 1'b0},
        '{OP_MULHI_I24, 64'h0080_0000, 64'h007F_FFFF, 1'b0, 64'h0, 1'b0},
        '{OP_MULHI_U24, AllOnes, AllOnes, 1'b0, 64'h0, 1'b0},
        '{OP_MIN_I32,   64'h8000_0000, 64'h7FFF_FFFF, 1'b1, 64'h8000_0000, 1'b0},
        '{OP_MAX_I32,   64'h8000_0000, 64'h7FFF_FFFF, 1'b1, 64'h7FFF_FFFF, 1'b0},
        '{OP_MIN_U32,   64'h8000_0000, 64'h7FFF_FFFF, 1'b1, 64'h7FFF_FFFF, 1'b0},
        '{OP_MAX_U32,   64'h8000_0000, 64'h7FFF_FFFF, 1'b1, 64'h8000_0000, 1'b0},
        '{OP_AND32,     AllOnes, AllOnes, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_OR32,      64'h0, 64'h0, 1'b1, 64'h0, 1'b0},
        '{OP_XOR32,     AllOnes, 64'h0, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_XNOR32,    64'h0, 64'h0, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_LSHLREV32, AllOnes, 64'h1, 1'b1, 64'h8000_0000, 1'b0},
        '{OP_LSHRREV32, 64'hFFFF_FFFF_FFFF_FFE0, 64'hFFFF_FFFF_8000_0000,
          1'b1, 64'h8000_0000, 1'b0},
        '{OP_ASHRREV32, 64'h1F, 64'h8000_0000, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
        '{OP_ASHRREV32, 64'h20, 64'h8000_0000, 1'b1, 64'h8000_0000, 1'b0},
        '{OP_ADD64,     AllOnes, 64'h1, 1'b1, 64'h0, 1'b1},
        '{OP_SUB64,     64'h0, 64'h1, 1'b1, AllOnes, 1'b1},
        '{OP_MUL64,     AllOnes, AllOnes, 1'b1, 64'h1, 1'b1},
        '{OP_LSHLREV64, AllOnes, 64'h1, 1'b1, 64'h8000_0000_0000_0000, 1'b1},
        '{OpUnusedLo,   AllOnes, AllOnes, 1'b1, 64'h0, 1'b0},
        '{OpUnusedHi,   AllOnes, AllOnes, 1'b1, 64'h0, 1'b0}
    };

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [2*DataW-1:0]  i_s_tdata  = '0;  // src_a, src_b
    logic [ReqTypeW-1:0] i_s_tuser  = '0;  // req_type
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [DataW-1:0]    o_m_tdata;        // result_value
    logic                o_m_tuser;        // result_is_wide

    t_alu_word pending_results[$];
    int        mismatch_count = 0;
    int        sender_idle_pct = 0;
    int        sink_stall_pct  = 0;

    vector_two_source_alu dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_alu_word alu_predict(logic [ReqTypeW-1:0] op,
                                              logic [DataW-1:0] a,
                                              logic [DataW-1:0] b);
        logic [HalfW-1:0] a32;
        logic [HalfW-1:0] b32;
        logic [DataW-1:0] sprod;
        logic [DataW-1:0] uprod;
        t_alu_word        res;
        a32   = a[HalfW-1:0];
        b32   = b[HalfW-1:0];
        sprod = {{40{a[23]}}, a[23:0]} * {{40{b[23]}}, b[23:0]};
        uprod = {40'b0, a[23:0]} * {40'b0, b[23:0]};
        res   = '0;
        case (op)
            OP_ADD32:     res.value[31:0] = a32 + b32;
            OP_SUB32:     res.value[31:0] = a32 - b32;
            OP_SUBREV32:  res.value[31:0] = b32 - a32;
            OP_MUL_I24:   res.value[31:0] = sprod[31:0];
            OP_MUL_U24:   res.value[31:0] = uprod[31:0];
            OP_MULHI_I24: res.value[31:0] = sprod[63:32];
            OP_MULHI_U24: res.value[31:0] = uprod[63:32];
            OP_MIN_I32:   res.value[31:0] = ($signed(a32) < $signed(b32)) ? a32 : b32;
            OP_MAX_I32:   res.value[31:0] = ($signed(a32) > $signed(b32)) ? a32 : b32;
            OP_MIN_U32:   res.value[31:0] = (a32 < b32) ? a32 : b32;
            OP_MAX_U32:   res.value[31:0] = (a32 > b32) ? a32 : b32;
            OP_AND32:     res.value[31:0] = a32 & b32;
            OP_OR32:      res.value[31:0] = a32 | b32;
            OP_XOR32:     res.value[31:0] = a32 ^ b32;
            OP_XNOR32:    res.value[31:0] = ~(a32 ^ b32);
            OP_LSHLREV32: res.value[31:0] = b32 << a[Sh32W-1:0];
            OP_LSHRREV32: res.value[31:0] = b32 >> a[Sh32W-1:0];
            OP_ASHRREV32: res.value[31:0] = $signed(b32) >>> a[Sh32W-1:0];
            OP_ADD64: begin
                res.value = a + b;
                res.wide  = 1'b1;
            end
            OP_SUB64: begin
                res.value = a - b;
                res.wide  = 1'b1;
            end
            OP_MUL64: begin
                res.value = a * b;
                res.wide  = 1'b1;
            end
            OP_LSHLREV64: begin
                res.value = b << a[Sh64W-1:0];
                res.wide  = 1'b1;
            end
            default: res = '0;
        endcase
        return res;
    endfunction

    // Operands lean towards zero, small, sign, 24-bit and all-ones values, with
    // the upper half mostly left random so that ignored bits are exercised.
    function automatic logic [DataW-1:0] pick_operand();
        logic [DataW-1:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            2: v[31:0] = 32'h8000_0000;
            3: v[31:0] = 32'h7FFF_FFFF;
            4: v[31:0] = {8'h00, 24'h80_0000};
            5: v[23:0] = 24'hFF_FFFF;
            6: v = DataW'($urandom_range(0, 70));
            default: ;
        endcase
        return v;
    endfunction

    task automatic issue_op(input logic [ReqTypeW-1:0] op, input logic [DataW-1:0] a,
                            input logic [DataW-1:0] b, input logic fixed,
                            input t_alu_word fixed_res);
        t_alu_word due;
        due = fixed ? fixed_res : alu_predict(op, a, b);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {b, a};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        pending_results.push_back(due);
    endtask

    task automatic issue_random();
        logic [ReqTypeW-1:0] op;
        if ($urandom_range(0, 19) == 0) begin
            op = ReqTypeW'($urandom_range(OpUnusedLo, OpUnusedHi));
        end else begin
            op = ReqTypeW'($urandom_range(OP_ADD32, OP_LSHLREV64));
        end
        issue_op(op, pick_operand(), pick_operand(), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    always @(posedge i_clk) begin
        t_alu_word want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result transfer value %h wide %b",
                         $time, o_m_tdata, o_m_tuser);
            end else begin
                want = pending_results.pop_front();
                if (o_m_tdata !== want.value) begin
                    mismatch_count++;
                    $display("%0t: result_value expected %h actual %h",
                             $time, want.value, o_m_tdata);
                end
                if (o_m_tuser !== want.wide) begin
                    mismatch_count++;
                    $display("%0t: result_is_wide expected %b actual %b",
                             $time, want.wide, o_m_tuser);
                end
            end
        end
    end

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        sender_idle_pct = 11;
        sink_stall_pct  = 50;
        for (int i = 0; i < DirCount; i++) begin
            issue_op(DirRows[i].op, DirRows[i].a, DirRows[i].b, DirRows[i].fixed,
                     '{value: DirRows[i].value, wide: DirRows[i].wide});
        end

        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 50 : 0;
            sink_stall_pct  = (phase == 0) ? 50 : (phase == 1) ? 11 : 0;
            for (int i = 0; i < PhaseItems; i++) begin
                if (phase == 1 && i == PhaseItems / 2) begin
                    i_s_tvalid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_results.size() != 0) @(posedge i_clk);
                end
                issue_random();
            end
        end

        i_s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/vtsa_pkg.sv
sv/vtsa_int_unit.sv
sv/vtsa_mul_unit.sv
sv/vector_two_source_alu.sv
dv/tb.sv
